// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared constants, codes and types of the indexed list shift store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int ILS_CAPACITY = 64;
    localparam int ILS_VALUE_W  = 32;
    localparam int ILS_IDX_W    = $clog2(ILS_CAPACITY);
    localparam int ILS_CNT_W    = ILS_IDX_W + 1;
    localparam int ILS_OP_W     = 3;
    localparam int ILS_ST_W     = 2;

    typedef logic [ILS_OP_W-1:0] t_op;
    typedef logic [ILS_ST_W-1:0] t_status;

    localparam t_op OP_INSERT_AT     = 3'd0;
    localparam t_op OP_DELETE_AT     = 3'd1;
    localparam t_op OP_LOCATE        = 3'd2;
    localparam t_op OP_RETRIEVE      = 3'd3;
    localparam t_op OP_INSERT_SORTED = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_POS   = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    // request fields broadcast to every cell
    typedef struct packed {
        t_op                            op;
        logic signed [ILS_VALUE_W-1:0]  value;
        logic [ILS_CNT_W-1:0]           pos;
        logic [ILS_CNT_W-1:0]           count;
        logic                           commit;
    } t_bcast;

    // hit carry passed up the chain
    typedef struct packed {
        logic                           hit;
        logic [ILS_IDX_W-1:0]           idx;
        logic signed [ILS_VALUE_W-1:0]  data;
    } t_up;

endpackage

// ===== rtl/ils_ifs.sv =====
// ----------------------------------------------------------------------------
// ils_ifs
// Request and response channels of the indexed list shift store.
// ----------------------------------------------------------------------------
interface ils_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [ils_pkg::ILS_OP_W-1:0]           opcode;
    logic signed [ils_pkg::ILS_VALUE_W-1:0] value;
    logic [ils_pkg::ILS_CNT_W-1:0]          position;

    modport source (output valid, opcode, value, position, input ready);
    modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface ils_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [ils_pkg::ILS_ST_W-1:0]           status;
    logic signed [ils_pkg::ILS_VALUE_W-1:0] found_value;
    logic [ils_pkg::ILS_IDX_W-1:0]          found_index;
    logic [ils_pkg::ILS_CNT_W-1:0]          entry_total;

    modport source (output valid, status, found_value, found_index, entry_total,
                    input ready);
    modport sink   (input valid, status, found_value, found_index, entry_total,
                    output ready);
endinterface

// ===== rtl/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One list entry with its compare logic and the carries passed to neighbors.
// ----------------------------------------------------------------------------
module ils_cell (
    input  logic                                   i_clk,
    input  ils_pkg::t_bcast                        i_bc,
    input  logic [ils_pkg::ILS_IDX_W-1:0]          i_idx,
    input  logic signed [ils_pkg::ILS_VALUE_W-1:0] i_left_data,
    input  logic signed [ils_pkg::ILS_VALUE_W-1:0] i_right_data,
    input  logic                                   i_left_ge,
    input  logic                                   i_right_ge,
    input  ils_pkg::t_up                           i_up,
    output logic signed [ils_pkg::ILS_VALUE_W-1:0] o_data,
    output logic                                   o_ge,
    output ils_pkg::t_up                           o_up
);
    import ils_pkg::*;

    logic signed [ILS_VALUE_W-1:0] r_data;
    logic                          r_ge;
    t_up                           r_up;
    logic [ILS_CNT_W-1:0]          w_idx_ext;
    logic                          w_valid;
    logic                          w_gt;
    logic                          w_hit;

    assign w_idx_ext = {1'b0, i_idx};
    assign w_valid   = w_idx_ext < i_bc.count;
    assign w_gt      = r_data > i_bc.value;
    assign w_hit     = (i_bc.op == OP_LOCATE) ? (w_valid && (r_data == i_bc.value))
                                              : (w_idx_ext == i_bc.pos);

    always_ff @(posedge i_clk) begin
        // every entry from here to the top is greater than the value
        r_ge <= (!w_valid || w_gt) && i_right_ge;

        if (i_up.hit) begin
            r_up <= i_up;
        end else begin
            r_up.hit  <= w_hit;
            r_up.idx  <= i_idx;
            r_up.data <= r_data;
        end

        if (i_bc.commit) begin
            case (i_bc.op)
                OP_INSERT_AT: begin
                    if (w_idx_ext == i_bc.pos) begin
                        r_data <= i_bc.value;
                    end else if (w_idx_ext > i_bc.pos) begin
                        r_data <= i_left_data;
                    end
                end
                OP_DELETE_AT: begin
                    if (w_idx_ext >= i_bc.pos) begin
                        r_data <= i_right_data;
                    end
                end
                OP_INSERT_SORTED: begin
                    if (i_left_ge) begin
                        r_data <= i_left_data;
                    end else if (r_ge) begin
                        r_data <= i_bc.value;
                    end
                end
                default: begin
                    r_data <= r_data;
                end
            endcase
        end
    end

    assign o_data = r_data;
    assign o_ge   = r_ge;
    assign o_up   = r_up;

endmodule

// ===== rtl/ils_chain.sv =====
// ----------------------------------------------------------------------------
// ils_chain
// Row of list cells; shift data moves sideways, hit carries move up and
// greater-than carries move down one cell per clock.
// ----------------------------------------------------------------------------
module ils_chain (
    input  logic            i_clk,
    input  ils_pkg::t_bcast i_bc,
    output ils_pkg::t_up    o_up
);
    import ils_pkg::*;

    logic signed [ILS_VALUE_W-1:0] w_data [ILS_CAPACITY];
    logic                          w_ge   [ILS_CAPACITY];
    t_up                           w_up   [ILS_CAPACITY];

    for (genvar i = 0; i < ILS_CAPACITY; i++) begin : g_cell
        logic signed [ILS_VALUE_W-1:0] w_left_data;
        logic signed [ILS_VALUE_W-1:0] w_right_data;
        logic                          w_left_ge;
        logic                          w_right_ge;
        t_up                           w_up_in;

        if (i == 0) begin : g_first
            assign w_left_data = '0;
            assign w_left_ge   = 1'b0;
            assign w_up_in     = '0;
        end else begin : g_inner_l
            assign w_left_data = w_data[i-1];
            assign w_left_ge   = w_ge[i-1];
            assign w_up_in     = w_up[i-1];
        end

        if (i == ILS_CAPACITY - 1) begin : g_last
            assign w_right_data = '0;
            assign w_right_ge   = 1'b1;
        end else begin : g_inner_r
            assign w_right_data = w_data[i+1];
            assign w_right_ge   = w_ge[i+1];
        end

        ils_cell u_cell (
            .i_clk        (i_clk),
            .i_bc         (i_bc),
            .i_idx        (ILS_IDX_W'(i)),
            .i_left_data  (w_left_data),
            .i_right_data (w_right_data),
            .i_left_ge    (w_left_ge),
            .i_right_ge   (w_right_ge),
            .i_up         (w_up_in),
            .o_data       (w_data[i]),
            .o_ge         (w_ge[i]),
            .o_up         (w_up[i])
        );
    end

    assign o_up = w_up[ILS_CAPACITY-1];

endmodule

// ===== rtl/indexed_list_shift_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_shift_store
// Bounded list of signed entries with indexed insert and delete, locate,
// retrieve and ascending insert, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// One request is handled at a time. Insert at a position, delete at a
// position, unused opcodes and requests rejected for position or fullness
// go from S_IDLE straight to S_DONE, which writes the response register
// when it is free or being taken; the next request can then transfer.
// Locate, retrieve and insert sorted pass through S_RUN before S_DONE
// while their carries ripple through the cell row, one cell per clock.
// A response waiting in the output register does not hold back the next
// request; only a second finished response waits for it to be taken.
// ----------------------------------------------------------------------------
module indexed_list_shift_store (
    input  logic i_clk,
    input  logic i_rst_n,
    ils_req_if.sink   i_req,
    ils_rsp_if.source o_rsp
);
    import ils_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                        r_state;
    t_op                           r_op;
    logic signed [ILS_VALUE_W-1:0] r_val;
    logic [ILS_CNT_W-1:0]          r_pos;
    logic [ILS_CNT_W-1:0]          r_count;
    logic [ILS_IDX_W-1:0]          r_run_cnt;
    t_status                       r_status;
    logic                          r_write;
    logic                          r_out_valid;
    t_status                       r_out_status;
    logic signed [ILS_VALUE_W-1:0] r_out_value;
    logic [ILS_IDX_W-1:0]          r_out_index;
    logic [ILS_CNT_W-1:0]          r_out_total;

    t_bcast                        w_bc;
    t_up                           w_top;
    logic                          w_done_go;
    logic                          w_full;
    logic [ILS_CNT_W-1:0]          n_count;

    assign w_full    = r_count == ILS_CNT_W'(ILS_CAPACITY);
    assign w_done_go = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign w_bc.op     = r_op;
    assign w_bc.value  = r_val;
    assign w_bc.pos    = r_pos;
    assign w_bc.count  = r_count;
    assign w_bc.commit = w_done_go && r_write;

    ils_chain u_chain (
        .i_clk (i_clk),
        .i_bc  (w_bc),
        .o_up  (w_top)
    );

    always_comb begin
        n_count = r_count;
        if (r_write) begin
            case (r_op)
                OP_INSERT_AT, OP_INSERT_SORTED: n_count = r_count + ILS_CNT_W'(1);
                OP_DELETE_AT:                   n_count = r_count - ILS_CNT_W'(1);
                default:                        n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_write     <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op      <= i_req.opcode;
                        r_val     <= i_req.value;
                        r_pos     <= i_req.position;
                        r_run_cnt <= '0;
                        r_status  <= ST_OK;
                        r_write   <= 1'b0;
                        r_state   <= S_DONE;
                        case (i_req.opcode)
                            OP_INSERT_AT: begin
                                if (i_req.position > r_count) begin
                                    r_status <= ST_BAD_POS;
                                end else if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_write <= 1'b1;
                                end
                            end
                            OP_DELETE_AT: begin
                                if (i_req.position >= r_count) begin
                                    r_status <= ST_BAD_POS;
                                end else begin
                                    r_write <= 1'b1;
                                end
                            end
                            OP_LOCATE: begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_RUN;
                            end
                            OP_RETRIEVE: begin
                                if (i_req.position >= r_count) begin
                                    r_status <= ST_BAD_POS;
                                end else begin
                                    r_state <= S_RUN;
                                end
                            end
                            OP_INSERT_SORTED: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_write <= 1'b1;
                                    r_state <= S_RUN;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_run_cnt <= r_run_cnt + ILS_IDX_W'(1);
                    if (r_run_cnt == ILS_IDX_W'(ILS_CAPACITY - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_done_go) begin
                        r_out_valid  <= 1'b1;
                        r_out_total  <= n_count;
                        r_count      <= n_count;
                        r_out_status <= r_status;
                        r_out_value  <= '0;
                        r_out_index  <= '0;
                        if (r_op == OP_LOCATE && w_top.hit) begin
                            r_out_status <= ST_OK;
                            r_out_index  <= w_top.idx;
                        end
                        if (r_op == OP_RETRIEVE && r_status == ST_OK) begin
                            r_out_value <= w_top.data;
                        end
                        r_write <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = r_state == S_IDLE;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_value;
    assign o_rsp.found_index = r_out_index;
    assign o_rsp.entry_total = r_out_total;

endmodule

// ===== tb/indexed_list_shift_store_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_shift_store_test
// Drives insert, delete, locate, retrieve and sorted-insert requests into the
// list store. Each accepted request runs through a local copy of the list,
// and each response is checked field by field against that prediction.
// The run has a directed opening, then random phases that fill and drain the
// list under different amounts of source idling and sink stalling.
// ----------------------------------------------------------------------------
module indexed_list_shift_store_test;
    import ils_pkg::*;

    localparam t_op OP_FIRST_SPARE = 3'd5;
    localparam t_op OP_LAST_SPARE  = 3'd7;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  DRAIN_CYCLES   = 80;
    localparam int  PHASE_ITEMS    = 385;

    typedef struct {
        t_op                           op;
        logic signed [ILS_VALUE_W-1:0] value;
        logic [ILS_CNT_W-1:0]          pos;
    } t_list_req;

    typedef struct {
        t_status                       status;
        logic signed [ILS_VALUE_W-1:0] found_value;
        logic [ILS_IDX_W-1:0]          found_index;
        logic [ILS_CNT_W-1:0]          entry_total;
    } t_list_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ils_req_if req_ch ();
    ils_rsp_if rsp_ch ();

    indexed_list_shift_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_list_req                     request_queue[$];
    t_list_rsp                     pending_responses[$];
    logic signed [ILS_VALUE_W-1:0] list_mem[ILS_CAPACITY];
    int                            list_count = 0;
    logic signed [ILS_VALUE_W-1:0] value_pool[16];
    int                            pool_wr = 0;
    bit                            draining = 1'b0;
    int                            error_count = 0;
    int                            src_idle_pct = 0;
    int                            rsp_stall_pct = 0;
    bit                            hold_armed = 1'b0;
    bit                            hold_done;
    int                            rsp_hold_left;

    task automatic note_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // shadow list update for one accepted request
    function automatic t_list_rsp apply_list_request(input t_list_req rq);
        t_list_rsp r;
        int i;
        r.status = ST_OK;
        r.found_value = '0;
        r.found_index = '0;
        case (rq.op)
            OP_INSERT_AT: begin
                if (rq.pos > list_count) begin
                    r.status = ST_BAD_POS;
                end else if (list_count >= ILS_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_count; i > rq.pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[rq.pos] = rq.value;
                    list_count++;
                end
            end
            OP_DELETE_AT: begin
                if (rq.pos >= list_count) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (i = rq.pos; i + 1 < list_count; i++)
                        list_mem[i] = list_mem[i+1];
                    list_count--;
                end
            end
            OP_LOCATE: begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < list_count; i++) begin
                    if (r.status == ST_NOT_FOUND && list_mem[i] == rq.value) begin
                        r.status = ST_OK;
                        r.found_index = ILS_IDX_W'(i);
                    end
                end
            end
            OP_RETRIEVE: begin
                if (rq.pos >= list_count)
                    r.status = ST_BAD_POS;
                else
                    r.found_value = list_mem[rq.pos];
            end
            OP_INSERT_SORTED: begin
                if (list_count >= ILS_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    i = list_count;
                    while (i > 0 && list_mem[i-1] > rq.value) begin
                        list_mem[i] = list_mem[i-1];
                        i--;
                    end
                    list_mem[i] = rq.value;
                    list_count++;
                end
            end
            default: ;
        endcase
        r.entry_total = ILS_CNT_W'(list_count);
        return r;
    endfunction

    function automatic logic signed [ILS_VALUE_W-1:0] pick_value(input bit prefer_pool);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (prefer_pool ? 70 : 30))
            return value_pool[$urandom_range(0, 15)];
        if (roll < (prefer_pool ? 85 : 45)) begin
            case ($urandom_range(0, 4))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh0000_0000;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_request(input t_op op, input logic signed [ILS_VALUE_W-1:0] value,
                                 input int pos);
        t_list_req rq;
        rq.op = op;
        rq.value = value;
        rq.pos = ILS_CNT_W'(pos);
        while (request_queue.size() >= 2)
            @(negedge i_clk);
        request_queue.push_back(rq);
    endtask

    // fill mode leans toward inserts, drain mode toward deletes
    task automatic queue_random_request();
        int roll;
        int cnt;
        int top;
        int pos;
        t_op op;
        logic signed [ILS_VALUE_W-1:0] value;
        cnt = list_count;
        if (draining && cnt == 0 && $urandom_range(0, 3) == 0)
            draining = 1'b0;
        else if (!draining && cnt == ILS_CAPACITY && $urandom_range(0, 7) == 0)
            draining = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            op = t_op'($urandom_range(OP_LAST_SPARE, OP_FIRST_SPARE));
        else if (draining)
            op = roll < 12 ? OP_INSERT_AT : roll < 22 ? OP_INSERT_SORTED :
                 roll < 62 ? OP_DELETE_AT : roll < 81 ? OP_LOCATE : OP_RETRIEVE;
        else
            op = roll < 32 ? OP_INSERT_AT : roll < 57 ? OP_INSERT_SORTED :
                 roll < 65 ? OP_DELETE_AT : roll < 82 ? OP_LOCATE : OP_RETRIEVE;
        value = pick_value(op == OP_LOCATE);
        top = (op == OP_INSERT_AT) ? cnt : (cnt > 0 ? cnt - 1 : 0);
        case ($urandom_range(0, 9))
            0:       pos = $urandom_range(0, ILS_CAPACITY);
            1:       pos = cnt;
            default: pos = $urandom_range(0, top);
        endcase
        if (op == OP_INSERT_AT || op == OP_INSERT_SORTED) begin
            value_pool[pool_wr] = value;
            pool_wr = (pool_wr + 1) % 16;
        end
        queue_request(op, value, pos);
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
        @(negedge i_clk);
        src_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (items)
            queue_random_request();
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_requests
        t_list_req next_req;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_req = request_queue.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.opcode   <= next_req.op;
                req_ch.value    <= next_req.value;
                req_ch.position <= next_req.pos;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // predict on each request transfer
    always @(posedge i_clk) begin : watch_requests
        t_list_req seen;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            seen.op    = req_ch.opcode;
            seen.value = req_ch.value;
            seen.pos   = req_ch.position;
            pending_responses.push_back(apply_list_request(seen));
        end
    end

    // long sink hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_hold_left <= 0;
            hold_done     <= 1'b0;
        end else if (rsp_hold_left != 0) begin
            rsp_hold_left <= rsp_hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            rsp_hold_left <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= rsp_hold_left == 0 && $urandom_range(0, 99) >= rsp_stall_pct;
    end

    // check each response transfer
    always @(posedge i_clk) begin : check_responses
        t_list_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_responses.size() == 0) begin
                note_mismatch("response transfer with nothing outstanding");
            end else begin
                want = pending_responses.pop_front();
                if (rsp_ch.status !== want.status)
                    note_mismatch($sformatf("status got %0d want %0d",
                                            rsp_ch.status, want.status));
                if (rsp_ch.found_value !== want.found_value)
                    note_mismatch($sformatf("found_value got %0d want %0d",
                                            rsp_ch.found_value, want.found_value));
                if (rsp_ch.found_index !== want.found_index)
                    note_mismatch($sformatf("found_index got %0d want %0d",
                                            rsp_ch.found_index, want.found_index));
                if (rsp_ch.entry_total !== want.entry_total)
                    note_mismatch($sformatf("entry_total got %0d want %0d",
                                            rsp_ch.entry_total, want.entry_total));
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        foreach (value_pool[k])
            value_pool[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list, bad positions, edges of the value range
        queue_request(OP_RETRIEVE, 32'sd0, 0);
        queue_request(OP_DELETE_AT, 32'sd0, 0);
        queue_request(OP_LOCATE, 32'sd5, 0);
        queue_request(OP_INSERT_AT, 32'sd7, 1);
        queue_request(OP_INSERT_AT, 32'sh7FFF_FFFF, 0);
        queue_request(OP_INSERT_AT, 32'sh8000_0000, 0);
        queue_request(OP_INSERT_AT, 32'sd0, 2);
        queue_request(OP_INSERT_AT, -32'sd1, 1);
        // equal values keep arrival order
        queue_request(OP_INSERT_SORTED, 32'sd5, 0);
        queue_request(OP_INSERT_SORTED, 32'sd5, 0);
        queue_request(OP_INSERT_SORTED, 32'sh8000_0000, 0);
        queue_request(OP_INSERT_SORTED, 32'sh7FFF_FFFF, 0);
        queue_request(OP_LOCATE, 32'sd5, 0);
        queue_request(OP_LOCATE, -32'sd1, 0);
        queue_request(OP_LOCATE, 32'sd12345, 0);
        queue_request(OP_RETRIEVE, 32'sd0, 0);
        queue_request(OP_RETRIEVE, 32'sd0, ILS_CAPACITY);
        queue_request(OP_RETRIEVE, 32'sd0, 7);
        queue_request(OP_DELETE_AT, 32'sd0, 7);
        queue_request(OP_DELETE_AT, 32'sd0, 0);
        queue_request(OP_DELETE_AT, 32'sd0, ILS_CAPACITY);
        for (int k = OP_FIRST_SPARE; k <= OP_LAST_SPARE; k++)
            queue_request(t_op'(k), -32'sd1, ILS_CAPACITY);
        queue_request(OP_INSERT_AT, 32'sh5555_5555, 6);

        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 61, 0);
        run_phase(PHASE_ITEMS, 0, 61);
        run_phase(PHASE_ITEMS, 30, 30);
        @(negedge i_clk);
        src_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_armed = 1'b1;
        repeat (PHASE_ITEMS)
            queue_random_request();

        while (request_queue.size() != 0 || req_ch.valid || pending_responses.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("indexed_list_shift_store_test: PASS");
        else
            $display("indexed_list_shift_store_test: FAIL");
        $finish;
    end

    initial begin
        #(16_000_000);
        $display("timeout");
        $display("indexed_list_shift_store_test: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ils_pkg.sv
rtl/ils_ifs.sv
rtl/ils_cell.sv
rtl/ils_chain.sv
rtl/indexed_list_shift_store.sv
tb/indexed_list_shift_store_test.sv
